// ===== design/mbp_pkg.sv =====
package mbp_pkg;

  // Item opcodes
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_ALIGN    = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int BYTE_BITS           = 8;
  localparam int MAX_FIELD_BITS      = 64;
  localparam int BYTES_PER_JOB       = 8;
  localparam int SHOWN_TOTAL_WIDTH   = 32;
  localparam int TOTAL_WIDTH_DEFAULT = 32;
  localparam int JOB_QUEUE_DEPTH     = 2;

  // One decoded item: up to eight finished bytes, first byte in the top lane
  typedef struct packed {
    logic [MAX_FIELD_BITS-1:0]    bytes;
    logic [2:0]                   last_idx;
    logic [SHOWN_TOTAL_WIDTH-1:0] total;
  } job_t;

endpackage

// ===== design/mbp_front.sv =====
module mbp_front #(
  parameter int TOTAL_COUNT_WIDTH = mbp_pkg::TOTAL_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                queue_full,
  input  logic [1:0]          opcode,
  input  logic [63:0]         value,
  input  logic [6:0]          bit_count,
  output mbp_pkg::job_t       job,
  output logic                job_valid
);
  import mbp_pkg::*;

  logic [6:0]                   pending_bits, pending_bits_next;
  logic [2:0]                   pending_count, pending_count_next;
  logic [TOTAL_COUNT_WIDTH-1:0] total_bits, total_bits_next;

  logic                         accept;
  logic [6:0]                   count_sat;
  logic [63:0]                  value_al;
  logic [7:0]                   pend_al;
  logic [71:0]                  stream;
  logic [6:0]                   run_len;
  logic [3:0]                   nbytes;
  logic [2:0]                   rem_count;
  logic [7:0]                   rem_byte;
  logic [7:0]                   rem_shifted;
  logic [3:0]                   pad;

  assign accept = push && !queue_full;

  // Line up pending bits and the new field, MSB first, in one 72-bit word
  always_comb begin
    count_sat   = (bit_count > 7'd64) ? 7'd64 : bit_count;
    value_al    = value << (7'd64 - count_sat);
    pend_al     = {pending_bits, 1'b0} << (3'd7 - pending_count);
    stream      = {pend_al, 64'd0} | ({value_al, 8'd0} >> pending_count);
    run_len     = {4'd0, pending_count} + count_sat;
    nbytes      = run_len[6:3];
    rem_count   = run_len[2:0];
    rem_byte    = 8'd0;
    for (int k = 0; k <= BYTES_PER_JOB; k++) begin
      if (nbytes == 4'(k)) rem_byte = stream[71-8*k -: 8];
    end
    rem_shifted = rem_byte >> (4'd8 - {1'b0, rem_count});
    pad         = 4'd8 - {1'b0, pending_count};
  end

  // Next state and the job handed to the queue
  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    total_bits_next    = total_bits;
    job.bytes          = stream[71:8];
    job.last_idx       = 3'(nbytes - 4'd1);
    job_valid          = 1'b0;
    unique case (opcode)
      OP_WRITE: begin
        pending_bits_next  = rem_shifted[6:0];
        pending_count_next = rem_count;
        total_bits_next    = total_bits + TOTAL_COUNT_WIDTH'(count_sat);
        job_valid          = accept && (nbytes != 4'd0);
      end
      OP_ALIGN: begin
        if (pending_count != 3'd0) begin
          pending_bits_next  = 7'd0;
          pending_count_next = 3'd0;
          total_bits_next    = total_bits + TOTAL_COUNT_WIDTH'(pad);
          job.bytes          = {pend_al, 56'd0};
          job.last_idx       = 3'd0;
          job_valid          = accept;
        end
      end
      OP_CLEAR: begin
        pending_bits_next  = 7'd0;
        pending_count_next = 3'd0;
        total_bits_next    = '0;
      end
      default: ;
    endcase
    job.total = SHOWN_TOTAL_WIDTH'(total_bits_next);
  end

  // Packer state advances on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
      total_bits    <= '0;
    end else if (accept) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      total_bits    <= total_bits_next;
    end
  end

endmodule

// ===== design/mbp_fifo.sv =====
module mbp_fifo #(
  parameter int DEPTH = mbp_pkg::JOB_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mbp_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output mbp_pkg::job_t rd_job,
  output logic          rd_valid
);
  import mbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Job storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/mbp_back.sv =====
module mbp_back (
  input  logic          clk,
  input  logic          rst,
  input  mbp_pkg::job_t head,
  input  logic          head_valid,
  output logic          head_done,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic [31:0]   bits_total
);
  import mbp_pkg::*;

  logic [2:0] idx;
  logic [2:0] lane;
  logic       xfer;

  // Pick the current byte of the head job, first byte in the top lane
  assign lane        = ~idx;
  assign out_byte    = head.bytes[{lane, 3'b000} +: 8];
  assign last_of_run = (idx == head.last_idx);
  assign bits_total  = head.total;
  assign empty       = !head_valid;
  assign xfer        = pop && head_valid;
  assign head_done   = xfer && last_of_run;

  // Byte index within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (xfer) begin
      idx <= last_of_run ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

// ===== design/msb_first_bit_packer_unit.sv =====
// A byte caused by an input transfer is registered in the job queue and reaches the result
// ports once the jobs ahead of it drain. Throughput: one input item per cycle while the
// two-entry job queue has room; the result side moves one byte per cycle while pop is high,
// so an item of n bytes (up to 8 for a full 64-bit write) holds it until all n are popped.
// Reset: synchronous rst clears pending bits, the running bit count and the job queue.
module msb_first_bit_packer_unit #(
  parameter int TOTAL_COUNT_WIDTH = mbp_pkg::TOTAL_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [63:0] value,
  input  logic [6:0]  bit_count,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic [31:0] bits_total
);
  import mbp_pkg::*;

  job_t job, head;
  logic job_valid, queue_full, head_valid, head_done;

  assign full = queue_full;

  // Front: decode items and build byte jobs
  mbp_front #(.TOTAL_COUNT_WIDTH(TOTAL_COUNT_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_full (queue_full),
    .opcode     (opcode),
    .value      (value),
    .bit_count  (bit_count),
    .job        (job),
    .job_valid  (job_valid)
  );

  // Job queue between the two sides
  mbp_fifo #(.DEPTH(JOB_QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_valid),
    .wr_job   (job),
    .full     (queue_full),
    .rd_en    (head_done),
    .rd_job   (head),
    .rd_valid (head_valid)
  );

  // Back: drain each job a byte at a time
  mbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .head_done   (head_done),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bits_total  (bits_total)
  );

  // A job is only offered when the queue has room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !queue_full)
    else $error("job pushed into a full queue");

  // A clear never produces bytes
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (push && !full && opcode == OP_CLEAR) |-> !job_valid)
    else $error("clear produced a job");

  // Within a run the next byte follows at once with the same bit count
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_run) |=> (!empty && $stable(bits_total)))
    else $error("run broken before its last byte");

endmodule

// ===== test/mbp_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both sides of the bit packer and checks every byte that leaves it
module mbp_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [63:0] value,
  input  logic [6:0]  bit_count,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last_of_run,
  input  logic [31:0] bits_total,
  output int          bytes_owed,
  output int          fails
);
  import mbp_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [31:0] total;
  } packed_byte_t;

  // Shadow of the packer state, cleared while rst is high
  logic [7:0]   part_byte;
  int           part_cnt;
  logic [31:0]  bit_tally;
  packed_byte_t owed_q[$];

  // Work out the bytes one accepted item releases and queue them
  task automatic pack_item(input logic [1:0] op, input logic [63:0] val,
                           input logic [6:0] cnt);
    int           nbits;
    logic [7:0]   run_q[$];
    packed_byte_t rec;
    case (op)
      OP_WRITE: begin
        // counts above a full word saturate
        nbits = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(cnt);
        for (int i = nbits - 1; i >= 0; i--) begin
          part_byte = {part_byte[6:0], val[i]};
          part_cnt++;
          if (part_cnt == BYTE_BITS) begin
            run_q     = {run_q, part_byte};
            part_byte = '0;
            part_cnt  = 0;
          end
        end
        bit_tally = bit_tally + 32'(nbits);
      end
      OP_ALIGN: begin
        // nothing to pad when already on a byte boundary
        if (part_cnt != 0) begin
          run_q     = {run_q, 8'(part_byte << (BYTE_BITS - part_cnt))};
          bit_tally = bit_tally + 32'(BYTE_BITS - part_cnt);
          part_byte = '0;
          part_cnt  = 0;
        end
      end
      OP_CLEAR: begin
        part_byte = '0;
        part_cnt  = 0;
        bit_tally = '0;
      end
      default: ;
    endcase
    foreach (run_q[k]) begin
      rec.data  = run_q[k];
      rec.last  = (k == run_q.size() - 1);
      rec.total = bit_tally;
      owed_q    = {owed_q, rec};
    end
  endtask

  always @(posedge clk) begin
    packed_byte_t want;
    if (rst) begin
      part_byte = '0;
      part_cnt  = 0;
      bit_tally = '0;
      owed_q.delete();
    end else begin
      // output transfer: compare against the oldest byte owed
      if (pop && !empty) begin
        if (owed_q.size() == 0) begin
          $error("unexpected byte %0h with no transfer pending", out_byte);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            fails++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
            fails++;
          end
          if (bits_total !== want.total) begin
            $error("bits_total: expected %0d, got %0d", want.total, bits_total);
            fails++;
          end
        end
      end
      // input transfer
      if (push && !full)
        pack_item(opcode, value, bit_count);
    end
    bytes_owed <= owed_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mbp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [1:0]  opcode = OP_WRITE;
  logic [63:0] value = '0;
  logic [6:0]  bit_count = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [31:0] bits_total;
  int          bytes_owed;
  int          fails;

  int send_idle = 0;
  int drain_stall = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  msb_first_bit_packer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .value       (value),
    .bit_count   (bit_count),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bits_total  (bits_total)
  );

  mbp_stream_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .value       (value),
    .bit_count   (bit_count),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .bits_total  (bits_total),
    .bytes_owed  (bytes_owed),
    .fails       (fails)
  );

  // Byte sink: stalls at the rate of the current phase
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= drain_stall);
    end
  end

  // Offer one item and hold it until the packer takes it
  task automatic send_item(input logic [1:0] op, input logic [63:0] val,
                           input logic [6:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    opcode    <= op;
    value     <= val;
    bit_count <= cnt;
    do @(posedge clk); while (full);
  endtask

  // Stop sending until every owed byte has been taken
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
  endtask

  // Mostly writes of random width, with aligns, clears and the odd unused opcode
  task automatic rand_item;
    int          pick;
    logic [63:0] val;
    logic [6:0]  cnt;
    pick = $urandom_range(99);
    val  = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       cnt = 7'($urandom_range(8));
      1:       cnt = 7'(8);
      2:       cnt = 7'($urandom_range(64));
      default: cnt = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 65))
                                              : 7'($urandom_range(64, 33));
    endcase
    if (pick < 72)
      send_item(OP_WRITE, val, cnt);
    else if (pick < 86)
      send_item(OP_ALIGN, val, cnt);
    else if (pick < 94)
      send_item(OP_CLEAR, val, cnt);
    else
      send_item(OP_RESERVED, val, cnt);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edges of the fields and each special case
    send_item(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
    send_item(OP_WRITE, 64'h0, 7'd64);
    send_item(OP_WRITE, 64'hDEAD_BEEF_0123_4567, 7'd0);
    send_item(OP_WRITE, 64'h8000_0000_0000_0001, 7'd127);
    send_item(OP_WRITE, 64'hA5A5_5A5A_C3C3_3C3C, 7'd65);
    send_item(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
    send_item(OP_ALIGN, 64'h0, 7'd0);
    send_item(OP_ALIGN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_item(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFE5, 7'd5);
    send_item(OP_WRITE, 64'h0000_0000_0000_002B, 7'd7);
    send_item(OP_ALIGN, 64'h0, 7'd0);
    send_item(OP_WRITE, 64'h0000_0000_0000_0005, 7'd3);
    send_item(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_item(OP_WRITE, 64'h0000_0000_0000_00C3, 7'd8);
    send_item(OP_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_item(OP_WRITE, 64'h0000_0000_0000_0001, 7'd9);
    send_item(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
    send_item(OP_ALIGN, 64'h0, 7'd0);
    send_item(OP_CLEAR, 64'h0, 7'd0);
    drain();

    // Random phases: no idling, idle sender, stalling sink, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle   <= (ph == 1) ? 74 : (ph == 3) ? 23 : 0;
      drain_stall <= (ph == 2) ? 74 : (ph == 3) ? 23 : 0;
      for (int n = 0; n < 100; n++) rand_item();
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
